>>> rtl/nnact_pkg.sv
// ---------------------------------------------------------------------------
// nnact_pkg
// Shared types, constants and table-generation functions for the activation
// unit.
// ---------------------------------------------------------------------------
package nnact_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int KIND_W            = 3;
    localparam int DEF_TABLE_ENTRIES = 256;
    localparam int DEF_FRACTION_BITS = 12;

    // Leaky slope is LEAK_NUM / 2^LEAK_SHIFT, independent of the fraction width.
    localparam int LEAK_NUM   = 41;
    localparam int LEAK_SHIFT = 12;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    typedef enum logic [KIND_W-1:0] {
        ACT_IDENTITY = 3'd0,
        ACT_SIGMOID  = 3'd1,
        ACT_TANH     = 3'd2,
        ACT_RELU     = 3'd3,
        ACT_LEAKY    = 3'd4
    } act_kind_t;

    // Sigmoid of a nonnegative Q30 magnitude, in Q30. The exponential is a
    // fourth-order series at a/256, squared eight times.
    function automatic longint unsigned sig_q30_pos(input longint unsigned a);
        longint unsigned y;
        longint unsigned t2;
        longint unsigned t3;
        longint unsigned t4;
        longint unsigned e;
        longint unsigned den;
        longint unsigned rem;
        longint unsigned quo;
        int              i;
        y  = a >> 8;
        t2 = (y * y) >> 30;
        t3 = (t2 * y) >> 30;
        t4 = (t3 * y) >> 30;
        e  = Q30_ONE - y + t2 / 2 - t3 / 6 + t4 / 24;
        for (i = 0; i < 8; i++) begin
            e = (e * e) >> 30;
        end
        // 2^60 / (2^30 + e) by restoring long division; only the top bit of
        // the dividend is set.
        den = Q30_ONE + e;
        rem = 64'd0;
        quo = 64'd0;
        for (i = 60; i >= 0; i--) begin
            rem = (rem << 1) | ((i == 60) ? 64'd1 : 64'd0);
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // Table point at Q30 position pos on [0, 16], centered at 8, rounded
    // half up to fb fraction bits.
    function automatic longint unsigned sig_point(input longint unsigned pos, input int fb);
        longint unsigned mid;
        longint unsigned s;
        mid = 64'd8 << 30;
        if (pos >= mid) begin
            s = sig_q30_pos(pos - mid);
        end else begin
            s = Q30_ONE - sig_q30_pos(mid - pos);
        end
        return ((s << fb) + (Q30_ONE >> 1)) >> 30;
    endfunction

endpackage

>>> rtl/nnact_sig_rom.sv
// ---------------------------------------------------------------------------
// nnact_sig_rom
// Sigmoid table stage: looks up the segment base and slope for an index and
// registers them.
// ---------------------------------------------------------------------------
module nnact_sig_rom #(
    parameter int ENTRIES   = nnact_pkg::DEF_TABLE_ENTRIES,
    parameter int FRAC_BITS = nnact_pkg::DEF_FRACTION_BITS
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [$clog2(ENTRIES)-1:0]         idx,
    output logic signed [FRAC_BITS+1:0]        base_reg,
    output logic signed [FRAC_BITS+1:0]        delta_reg
);
    import nnact_pkg::*;

    localparam int TW = FRAC_BITS + 2;

    logic signed [TW-1:0] base_tab  [ENTRIES];
    logic signed [TW-1:0] delta_tab [ENTRIES];

    // Each segment holds its left end point and the step to the right one.
    for (genvar k = 0; k < ENTRIES; k++) begin : g_tab
        localparam longint unsigned POS_LO = (longint'(k) * 16 << 30) / ENTRIES;
        localparam longint unsigned POS_HI = (longint'(k + 1) * 16 << 30) / ENTRIES;
        localparam longint unsigned V_LO   = sig_point(POS_LO, FRAC_BITS);
        localparam longint unsigned V_HI   = sig_point(POS_HI, FRAC_BITS);
        localparam longint          V_D    = longint'(V_HI) - longint'(V_LO);
        assign base_tab[k]  = TW'(V_LO);
        assign delta_tab[k] = TW'(V_D);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            base_reg  <= base_tab[idx];
            delta_reg <= delta_tab[idx];
        end
    end

endmodule

>>> rtl/nn_activation_unit_top.sv
// ---------------------------------------------------------------------------
// nn_activation_unit_top
// Elementwise activation unit: identity, sigmoid, tanh, ReLU or leaky ReLU,
// or the derivative of the selected function, on signed fixed-point words.
// ---------------------------------------------------------------------------
// The unit takes one word per clock and returns one result word for each, in
// order. Each word passes through seven register stages: input capture,
// clamp and table index, table read, slope multiply, interpolate, derivative
// multiply, and select and saturate. Throughput is one word per cycle
// whenever m_tready is high; a stalled output lets the empty stages behind
// it keep filling. s_tuser carries the operation bit (0 function, 1
// derivative). The activation kind register is written through
// cfg_valid/cfg_data and should only change while no words are in flight.
module nn_activation_unit_top #(
    parameter int SIGMOID_TABLE_ENTRIES = nnact_pkg::DEF_TABLE_ENTRIES,
    parameter int FRACTION_BITS         = nnact_pkg::DEF_FRACTION_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration: activation kind.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nnact_pkg::KIND_W-1:0]      cfg_data,
    // Input words.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nnact_pkg::SAMPLE_W-1:0]    s_tdata,   // [15:0] sample
    input  logic                              s_tuser,   // [0] operation
    // Result words.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nnact_pkg::SAMPLE_W-1:0]    m_tdata    // [15:0] result
);
    import nnact_pkg::*;

    localparam int ENTRIES = SIGMOID_TABLE_ENTRIES;
    localparam int FB      = FRACTION_BITS;
    localparam int NST     = 7;
    localparam int NPASS   = 6;
    localparam int SW      = (FB + 6 > SAMPLE_W + 1) ? FB + 6 : SAMPLE_W + 1;
    localparam int UW      = FB + 5;
    localparam int EB      = $clog2(ENTRIES + 1);
    localparam int PW      = UW + EB;
    localparam int IW      = $clog2(ENTRIES);
    localparam int RMW     = FB + 4;
    localparam int TW      = FB + 2;
    localparam int QW      = TW + RMW + 1;
    localparam int VW      = TW + 1;
    localparam int MW      = 2 * VW;
    localparam int LW      = SAMPLE_W + 7;
    localparam int OW      = (FB + 4 > SAMPLE_W + 2) ? FB + 4 : SAMPLE_W + 2;

    localparam logic signed [SW-1:0] HALF_SPAN = SW'(longint'(8) << FB);
    localparam logic [EB:0]          ENT_CMP   = (EB + 1)'(ENTRIES);
    localparam logic signed [TW-1:0] TOP_VAL   = TW'(sig_point(64'd16 << 30, FB));
    localparam logic signed [VW-1:0] ONE_V     = VW'(longint'(1) << FB);
    localparam logic signed [OW-1:0] ONE_O     = OW'(longint'(1) << FB);
    localparam logic signed [OW-1:0] LEAK_DER  =
        OW'(((longint'(1) << FB) * LEAK_NUM + 2048) >> LEAK_SHIFT);
    localparam logic signed [OW-1:0] SAT_HI    = OW'(SAMPLE_MAX);
    localparam logic signed [OW-1:0] SAT_LO    = OW'(SAMPLE_MIN);

    // ---------------- control ----------------
    logic [KIND_W-1:0] act_kind_reg;
    logic [NST-1:0]    valid_reg;
    logic [NST:0]      en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_kind_reg <= ACT_IDENTITY;
        end else if (cfg_valid) begin
            act_kind_reg <= cfg_data;
        end
    end

    // A stage may load when it is empty or when the stage after it moves.
    always_comb begin
        en[NST] = m_tready;
        for (int i = NST - 1; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NST; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NST-1];

    // ---------------- side-band carried along the stages ----------------
    logic                        p_op_reg   [NPASS];
    logic [KIND_W-1:0]           p_kind_reg [NPASS];
    logic signed [SAMPLE_W-1:0]  p_x_reg    [NPASS];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            p_op_reg[0]   <= s_tuser;
            p_kind_reg[0] <= act_kind_reg;
            p_x_reg[0]    <= s_tdata;
        end
        for (int i = 1; i < NPASS; i++) begin
            if (en[i]) begin
                p_op_reg[i]   <= p_op_reg[i-1];
                p_kind_reg[i] <= p_kind_reg[i-1];
                p_x_reg[i]    <= p_x_reg[i-1];
            end
        end
    end

    // ---------------- stage 1: sigmoid argument and table index ----------------
    logic signed [SAMPLE_W:0]   x2;
    logic signed [SAMPLE_W-1:0] xs;
    logic signed [SW-1:0]       xe;
    logic signed [SW-1:0]       xc;
    logic signed [SW-1:0]       xu;
    logic [PW-1:0]              pos;
    logic                       b_top_next;
    logic [IW-1:0]              b_idx_next;
    logic [RMW-1:0]             b_rem_next;
    logic                       b_top_reg;
    logic [IW-1:0]              b_idx_reg;
    logic [RMW-1:0]             b_rem_reg;

    // Tanh evaluates the sigmoid at twice the sample, saturated to 16 bits.
    assign x2 = {p_x_reg[0], 1'b0};

    always_comb begin
        if (p_kind_reg[0] == ACT_TANH) begin
            if (x2[SAMPLE_W] != x2[SAMPLE_W-1]) begin
                xs = x2[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
            end else begin
                xs = x2[SAMPLE_W-1:0];
            end
        end else begin
            xs = p_x_reg[0];
        end
        xe = SW'(xs);
        if (xe < -HALF_SPAN) begin
            xc = -HALF_SPAN;
        end else if (xe > HALF_SPAN) begin
            xc = HALF_SPAN;
        end else begin
            xc = xe;
        end
        xu         = xc + HALF_SPAN;
        pos        = PW'(xu[UW-1:0]) * PW'(ENTRIES);
        b_top_next = pos[PW-1:RMW] >= ENT_CMP;
        b_idx_next = pos[RMW+IW-1:RMW];
        b_rem_next = pos[RMW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            b_top_reg <= b_top_next;
            b_idx_reg <= b_idx_next;
            b_rem_reg <= b_rem_next;
        end
    end

    // ---------------- stage 2: table read ----------------
    logic signed [TW-1:0] c_base_reg;
    logic signed [TW-1:0] c_delta_reg;
    logic                 c_top_reg;
    logic [RMW-1:0]       c_rem_reg;

    nnact_sig_rom #(
        .ENTRIES   (ENTRIES),
        .FRAC_BITS (FB)
    ) u_rom (
        .aclk      (aclk),
        .en        (en[2]),
        .idx       (b_idx_reg),
        .base_reg  (c_base_reg),
        .delta_reg (c_delta_reg)
    );

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            c_top_reg <= b_top_reg;
            c_rem_reg <= b_rem_reg;
        end
    end

    // ---------------- stage 3: slope times remainder ----------------
    logic signed [QW-1:0] d_prod_next;
    logic signed [TW-1:0] d_base_next;
    logic signed [QW-1:0] d_prod_reg;
    logic signed [TW-1:0] d_base_reg;

    // The upper end point has no segment to its right and is returned as is.
    always_comb begin
        if (c_top_reg) begin
            d_base_next = TOP_VAL;
            d_prod_next = '0;
        end else begin
            d_base_next = c_base_reg;
            d_prod_next = c_delta_reg * $signed({1'b0, c_rem_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            d_base_reg <= d_base_next;
            d_prod_reg <= d_prod_next;
        end
    end

    // ---------------- stage 4: interpolate, tanh rescale, leaky slope ----------------
    logic signed [QW-1:0]       d_shift;
    logic signed [VW-1:0]       s_val;
    logic signed [VW-1:0]       e_v_next;
    logic signed [LW-1:0]       leak_prod;
    logic signed [LW-1:0]       leak_shift;
    logic signed [VW-1:0]       e_v_reg;
    logic signed [SAMPLE_W-1:0] e_leak_reg;

    always_comb begin
        d_shift = d_prod_reg >>> RMW;
        s_val   = VW'(d_base_reg) + VW'(d_shift[TW-1:0]);
        if (p_kind_reg[3] == ACT_TANH) begin
            e_v_next = (s_val <<< 1) - ONE_V;
        end else begin
            e_v_next = s_val;
        end
        leak_prod  = LW'(p_x_reg[3]) * LW'(LEAK_NUM);
        leak_shift = leak_prod >>> LEAK_SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            e_v_reg    <= e_v_next;
            e_leak_reg <= leak_shift[SAMPLE_W-1:0];
        end
    end

    // ---------------- stage 5: derivative product ----------------
    logic signed [VW-1:0]       f_b;
    logic signed [MW-1:0]       f_prod_reg;
    logic signed [VW-1:0]       f_v_reg;
    logic signed [SAMPLE_W-1:0] f_leak_reg;

    // s*(1-s) for sigmoid, t*t for tanh.
    assign f_b = (p_kind_reg[4] == ACT_SIGMOID) ? ONE_V - e_v_reg : e_v_reg;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            f_prod_reg <= e_v_reg * f_b;
            f_v_reg    <= e_v_reg;
            f_leak_reg <= e_leak_reg;
        end
    end

    // ---------------- stage 6: select and saturate ----------------
    logic signed [MW-1:0]       f_q;
    logic signed [OW-1:0]       x_o;
    logic signed [OW-1:0]       y_sel;
    logic signed [SAMPLE_W-1:0] g_result_next;
    logic signed [SAMPLE_W-1:0] g_result_reg;
    logic                       neg;
    logic                       op;

    always_comb begin
        f_q = f_prod_reg >>> FB;
        x_o = OW'(p_x_reg[5]);
        neg = p_x_reg[5][SAMPLE_W-1];
        op  = p_op_reg[5];
        case (p_kind_reg[5])
            ACT_SIGMOID: y_sel = op ? OW'(f_q) : OW'(f_v_reg);
            ACT_TANH:    y_sel = op ? ONE_O - OW'(f_q) : OW'(f_v_reg);
            ACT_RELU: begin
                if (op) begin
                    y_sel = neg ? '0 : ONE_O;
                end else begin
                    y_sel = neg ? '0 : x_o;
                end
            end
            ACT_LEAKY: begin
                if (op) begin
                    y_sel = neg ? LEAK_DER : ONE_O;
                end else begin
                    y_sel = neg ? OW'(f_leak_reg) : x_o;
                end
            end
            default:     y_sel = op ? ONE_O : x_o;
        endcase
        if (y_sel > SAT_HI) begin
            g_result_next = SAMPLE_MAX;
        end else if (y_sel < SAT_LO) begin
            g_result_next = SAMPLE_MIN;
        end else begin
            g_result_next = y_sel[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            g_result_reg <= g_result_next;
        end
    end

    assign m_tdata = g_result_reg;

endmodule

>>> rtl/nnact_checker.sv
// ---------------------------------------------------------------------------
// nnact_checker
// Port-level checks for the activation unit, bound to the top level.
// ---------------------------------------------------------------------------
module nnact_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [nnact_pkg::SAMPLE_W-1:0] m_tdata
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // With the output free to move, the whole pipeline moves and input is taken.
    a_ready_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("s_tready low while the output side is not stalled");

    // Nothing can come out before a word has passed all seven stages after reset.
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_tvalid ##1 !m_tvalid ##1 !m_tvalid ##1 !m_tvalid
                           ##1 !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
        else $error("result word appeared before the pipeline latency");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

endmodule

bind nn_activation_unit_top nnact_checker u_nnact_checker (.*);
